// ===== design/tile_map_block_bitmap_unit_assert.svh =====
// Assertion macros for the tile map bitmap unit.
// Each use needs clk and rst in scope.
`ifndef TILE_MAP_BLOCK_BITMAP_UNIT_ASSERT_SVH
`define TILE_MAP_BLOCK_BITMAP_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TMBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TMBB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TMBB_ASSERT_IMP(lbl, ante, cons, msg)
`define TMBB_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/tmbb_pkg.sv =====
package tmbb_pkg;

  localparam int MAX_CELLS_DEF   = 262144;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int WORD_BITS       = 32;
  localparam int WORD_LSB        = 5;   // log2 of WORD_BITS
  localparam int CFG_W           = 10;
  localparam int CFG_IDX_W       = 1;
  localparam int CELLS_W         = 19;
  localparam int IDX_W           = 20;  // y * width + x, both below 1024
  localparam int SKIP_W          = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [7:0]         data_byte;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
  } cmd_t;

  typedef struct packed {
    logic               blocked;
    logic [CELLS_W-1:0] cells_loaded;
    logic               load_complete;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] map_width;
    logic [CFG_W-1:0] map_height;
  } cfg_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    mode_t            mode;
    logic [7:0]       data_byte;
    logic             out_of_range;
    logic [IDX_W-1:0] row_base;
    logic [CFG_W-1:0] col;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic near_full;
  } q_status_t;

  // Extra bytes that follow a flag byte.
  function automatic logic [SKIP_W-1:0] skip_length(input logic [7:0] flag);
    logic [SKIP_W-1:0] n;
    n = '0;
    if (flag[1]) n = n + SKIP_W'(2);
    if (flag[2]) n = n + SKIP_W'(2);
    if (flag[3]) n = n + SKIP_W'(4);
    if (flag[4]) n = n + SKIP_W'(1);
    if (flag[5]) n = n + SKIP_W'(1);
    if (flag[6]) n = n + SKIP_W'(1);
    if (flag[7]) n = n + SKIP_W'(1);
    return n;
  endfunction

endpackage

// ===== design/tmbb_front.sv =====
module tmbb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  tmbb_pkg::cmd_t   cmd,
  input  tmbb_pkg::cfg_t   cfg,
  output logic             push,
  output tmbb_pkg::entry_t entry
);

  logic                       neg;
  logic                       x_oor;
  logic                       y_oor;
  logic [tmbb_pkg::IDX_W-1:0] row_base;
  logic                       vld;
  tmbb_pkg::entry_t           ent;

  assign neg   = cmd.query_x[15] | cmd.query_y[15];
  assign x_oor = $unsigned(cmd.query_x) >= 16'(cfg.map_width);
  assign y_oor = $unsigned(cmd.query_y) >= 16'(cfg.map_height);
  // only meaningful when y is in range, so the low bits suffice
  assign row_base = tmbb_pkg::IDX_W'(cmd.query_y[tmbb_pkg::CFG_W-1:0])
                  * tmbb_pkg::IDX_W'(cfg.map_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= take;
    end
    if (take) begin
      ent.mode         <= cmd.mode;
      ent.data_byte    <= cmd.data_byte;
      ent.out_of_range <= neg | x_oor | y_oor;
      ent.row_base     <= row_base;
      ent.col          <= cmd.query_x[tmbb_pkg::CFG_W-1:0];
    end
  end

  assign push  = vld;
  assign entry = ent;

endmodule

// ===== design/tmbb_queue.sv =====
module tmbb_queue #(
  parameter int DEPTH = tmbb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tmbb_pkg::entry_t    push_data,
  input  logic                pop,
  output tmbb_pkg::entry_t    pop_data,
  output tmbb_pkg::q_status_t status
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  tmbb_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_pop;

  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CNTW'(push) - CNTW'(do_pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data         = slots[rd_ptr];
  assign status.empty     = (count == '0);
  assign status.full      = (count == CNTW'(DEPTH));
  assign status.near_full = (count >= CNTW'(DEPTH - 1));

endmodule

// ===== design/tmbb_back.sv =====
module tmbb_back #(
  parameter int MAX_CELLS = tmbb_pkg::MAX_CELLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  tmbb_pkg::entry_t  entry,
  input  tmbb_pkg::cfg_t    cfg,
  output logic              result_valid,
  output tmbb_pkg::result_t result
);

  localparam int CW    = $clog2(MAX_CELLS + 1);
  localparam int WORDS = (MAX_CELLS + tmbb_pkg::WORD_BITS - 1) / tmbb_pkg::WORD_BITS;
  localparam int AW    = $clog2(WORDS);
  localparam int LSB   = tmbb_pkg::WORD_LSB;

  logic [tmbb_pkg::WORD_BITS-1:0] mem [WORDS];
  logic [tmbb_pkg::WORD_BITS-1:0] mem_q;

  logic [CW-1:0]                  cell_index;
  logic [CW-1:0]                  cell_index_next;
  logic [tmbb_pkg::SKIP_W-1:0]    skip;
  logic [tmbb_pkg::SKIP_W-1:0]    skip_next;
  logic [tmbb_pkg::WORD_BITS-1:0] acc;
  logic [tmbb_pkg::WORD_BITS-1:0] acc_next;
  logic [CW-1:0]                  total;
  logic [CW-1:0]                  total_next;
  logic [2*tmbb_pkg::CFG_W-1:0]   area;

  logic                           wr_en;
  logic [tmbb_pkg::WORD_BITS-1:0] wr_word;
  logic [LSB-1:0]                 pos;

  logic [tmbb_pkg::IDX_W-1:0]     idx;
  logic                           beyond;
  logic                           in_loaded;
  logic                           same_word;
  logic                           q_from_mem;
  logic                           q_bit;

  logic                           res_valid;
  logic                           res_from_mem;
  logic                           res_bit;
  logic [LSB-1:0]                 res_sel;
  logic [tmbb_pkg::CELLS_W-1:0]   res_cells;
  logic                           res_complete;

  // cell total, saturated at storage size
  assign area       = (2*tmbb_pkg::CFG_W)'(cfg.map_width)
                    * (2*tmbb_pkg::CFG_W)'(cfg.map_height);
  assign total_next = (32'(area) > 32'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(area);

  assign pos = cell_index[LSB-1:0];

  always_comb begin
    cell_index_next = cell_index;
    skip_next       = skip;
    acc_next        = acc;
    wr_en           = 1'b0;
    wr_word         = acc;
    if (take) begin
      case (entry.mode)
        tmbb_pkg::MODE_START: begin
          cell_index_next = '0;
          skip_next       = '0;
          acc_next        = '0;
        end
        tmbb_pkg::MODE_BYTE: begin
          if (skip != '0) begin
            skip_next = skip - tmbb_pkg::SKIP_W'(1);
          end else if (cell_index < total) begin
            if (entry.data_byte[0]) begin
              acc_next[pos] = 1'b1;
            end
            if (pos == LSB'(tmbb_pkg::WORD_BITS - 1)) begin
              wr_en    = 1'b1;
              wr_word  = acc_next;
              acc_next = '0;
            end
            skip_next       = tmbb_pkg::skip_length(entry.data_byte);
            cell_index_next = cell_index + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // query: cells below the fill count are valid; the open word is in acc
  assign idx       = entry.row_base + tmbb_pkg::IDX_W'(entry.col);
  assign beyond    = 32'(idx) >= 32'(MAX_CELLS);
  assign in_loaded = 32'(idx) < 32'(cell_index);
  assign same_word = 32'(idx >> LSB) == 32'(cell_index >> LSB);

  always_comb begin
    q_from_mem = 1'b0;
    q_bit      = 1'b0;
    if (entry.mode == tmbb_pkg::MODE_QUERY) begin
      if (entry.out_of_range || beyond) begin
        q_bit = 1'b1;
      end else if (!in_loaded) begin
        q_bit = 1'b0;
      end else if (same_word) begin
        q_bit = acc[idx[LSB-1:0]];
      end else begin
        q_from_mem = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cell_index[AW+LSB-1:LSB]] <= wr_word;
    end
    mem_q <= mem[idx[AW+LSB-1:LSB]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_index <= '0;
      skip       <= '0;
      acc        <= '0;
      total      <= '0;
      res_valid  <= 1'b0;
    end else begin
      cell_index <= cell_index_next;
      skip       <= skip_next;
      acc        <= acc_next;
      total      <= total_next;
      res_valid  <= take;
    end
    res_from_mem <= q_from_mem;
    res_bit      <= q_bit;
    res_sel      <= idx[LSB-1:0];
    res_cells    <= tmbb_pkg::CELLS_W'(cell_index_next);
    res_complete <= (cell_index_next >= total);
  end

  assign result_valid         = res_valid;
  assign result.blocked       = res_from_mem ? mem_q[res_sel] : res_bit;
  assign result.cells_loaded  = res_cells;
  assign result.load_complete = res_complete;

endmodule

// ===== design/tile_map_block_bitmap_unit.sv =====
// Path: the front registers each accepted item, the queue holds it, and the back strobes its result.
// Throughput: one item per cycle while busy is low; the back end retires one queue entry a cycle.
// busy rises only if the front-to-back queue nears full.
// Reset (rst, synchronous, active high) clears counts, queue and registers;
// the bitmap memory needs no clearing pass (a fill count masks stale words).
// Results cannot be stalled by the receiver: one strobe per accepted item.
`include "tile_map_block_bitmap_unit_assert.svh"

module tile_map_block_bitmap_unit #(
  parameter int MAX_CELLS   = tmbb_pkg::MAX_CELLS_DEF,
  parameter int QUEUE_DEPTH = tmbb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // item channel
  input  logic                             start,
  output logic                             busy,
  input  tmbb_pkg::cmd_t                   cmd,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tmbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tmbb_pkg::CFG_W-1:0]       cfg_data,
  // result channel
  output logic                             result_valid,
  output tmbb_pkg::result_t                result
);

  // Structure:
  //   front  - registers the item, does the range checks and the
  //            row * width multiply for queries
  //   queue  - small FIFO of classified items
  //   back   - skip counter, fill count, open-word accumulator and the
  //            bitmap memory (one 32-bit word per 32 cells)
  // Tile records arrive in cell order, so only cells below the fill count
  // hold data from the current load; every word below the open one has
  // been written whole during this load. Stored cells past the fill count read 0.

  tmbb_pkg::cfg_t      cfg;
  logic                accept;
  logic                front_push;
  tmbb_pkg::entry_t    front_entry;
  tmbb_pkg::entry_t    q_entry;
  tmbb_pkg::q_status_t q_stat;
  logic                back_take;

  // Config registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width  <= '0;
      cfg.map_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (tmbb_pkg::cfg_reg_t'(cfg_index))
        tmbb_pkg::REG_MAP_WIDTH:  cfg.map_width  <= cfg_data;
        tmbb_pkg::REG_MAP_HEIGHT: cfg.map_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // One slot is held back for the item sitting in the front register.
  assign busy   = q_stat.near_full;
  assign accept = start && !busy;

  tmbb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (accept),
    .cmd   (cmd),
    .cfg   (cfg),
    .push  (front_push),
    .entry (front_entry)
  );

  tmbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_entry),
    .pop       (back_take),
    .pop_data  (q_entry),
    .status    (q_stat)
  );

  // The back end never stalls, so it takes an item whenever one waits.
  assign back_take = !q_stat.empty;

  tmbb_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .take         (back_take),
    .entry        (q_entry),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

  // Every accepted item is answered after the fixed pipeline depth.
  `TMBB_ASSERT_IMP(a_item_answered, start && !busy, ##3 result_valid, "item not answered in time")
  // Only a query can report a blocked cell.
  `TMBB_ASSERT_IMP(a_blocked_from_query, result_valid && result.blocked, $past(start && !busy && cmd.mode == tmbb_pkg::MODE_QUERY, 3), "blocked set on a non-query item")
  // The queue must never be pushed while full.
  `TMBB_ASSERT_NEVER(a_queue_no_overflow, q_stat.full && front_push, "queue overflow")

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmbb_pkg::*;

  // Generous ceiling for the whole work list at the slowest sender pacing.
  localparam int LIMIT_CYCLES = 100000;
  localparam int MAP_CELLS    = MAX_CELLS_DEF;
  localparam int REPORT_LINES = 30;

  // Work list entries: an item, a register write, a pause until every expected
  // result has come back, or a change of sender pacing.
  typedef enum {STIM_ITEM, STIM_REG, STIM_DRAIN, STIM_PACE} stim_kind_e;

  typedef struct {
    stim_kind_e       kind;
    cmd_t             cmd;
    cfg_reg_t         reg_sel;
    logic [CFG_W-1:0] value;
    int               idle_pct;
  } stim_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  cmd_t             cmd = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             result_valid;
  result_t          result;

  tile_map_block_bitmap_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Map model: its own copy of the registers, the blocked bits and the
  // record counter, advanced as each item is accepted.
  // ---------------------------------------------------------------------------
  bit               tile_blocked [MAP_CELLS];
  int               cells_taken = 0;   // flag bytes taken since the last start item
  int               skip_left = 0;     // extra record bytes still to discard
  logic [CFG_W-1:0] map_w = '0;
  logic [CFG_W-1:0] map_h = '0;

  stim_t            pending_items [$];
  result_t          tile_results_due [$];
  int               idle_pct = 0;
  int               mismatches = 0;
  int               cycle_count = 0;

  // Extra bytes trailing a flag byte; flag bits 1 to 7 each carry their own length.
  function automatic int extra_bytes(logic [7:0] flag);
    int n;
    n = 0;
    if (flag[1]) n += 2;
    if (flag[2]) n += 2;
    if (flag[3]) n += 4;
    for (int b = 4; b < 8; b++)
      if (flag[b]) n += 1;
    return n;
  endfunction

  // w * h, capped at the storage size
  function automatic int map_cells();
    int t;
    t = int'(map_w) * int'(map_h);
    return (t > MAP_CELLS) ? MAP_CELLS : t;
  endfunction

  function automatic logic query_blocked(logic [15:0] qx, logic [15:0] qy);
    int x, y, idx;
    x = {{16{qx[15]}}, qx};
    y = {{16{qy[15]}}, qy};
    if (x < 0 || y < 0) return 1'b1;
    if (x >= int'(map_w) || y >= int'(map_h)) return 1'b1;
    idx = y * int'(map_w) + x;
    if (idx >= MAP_CELLS) return 1'b1;   // position beyond the stored bits
    return tile_blocked[idx];
  endfunction

  function automatic result_t predict_tile_result(cmd_t c);
    result_t r;
    r = '0;
    case (c.mode)
      MODE_START: begin
        // only cells below the record count can have been set
        for (int i = 0; i < cells_taken; i++)
          tile_blocked[i] = 1'b0;
        cells_taken = 0;
        skip_left = 0;
      end
      MODE_BYTE: begin
        if (skip_left > 0) begin
          skip_left--;
        end else if (cells_taken < map_cells()) begin
          if (c.data_byte[0]) tile_blocked[cells_taken] = 1'b1;
          skip_left = extra_bytes(c.data_byte);
          cells_taken++;
        end
      end
      MODE_QUERY: begin
        r.blocked = query_blocked(c.query_x, c.query_y);
      end
      default: ;   // no operation
    endcase
    r.cells_loaded  = CELLS_W'(cells_taken);
    r.load_complete = (cells_taken >= map_cells());
    return r;
  endfunction

  function automatic void set_map_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (cfg_reg_t'(idx))
      REG_MAP_WIDTH:  map_w = val;
      REG_MAP_HEIGHT: map_h = val;
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatches < REPORT_LINES)
      $display("mismatch: %s got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Work list builders
  // ---------------------------------------------------------------------------
  function automatic void push_item(mode_t m, logic [7:0] b, logic [15:0] x, logic [15:0] y);
    stim_t s;
    s = '{kind: STIM_ITEM, cmd: '0, reg_sel: REG_MAP_WIDTH, value: '0, idle_pct: 0};
    s.cmd.mode      = m;
    s.cmd.data_byte = b;
    s.cmd.query_x   = x;
    s.cmd.query_y   = y;
    pending_items.push_back(s);
  endfunction

  function automatic void push_reg(cfg_reg_t sel, int val);
    stim_t s;
    s = '{kind: STIM_REG, cmd: '0, reg_sel: sel, value: CFG_W'(val), idle_pct: 0};
    pending_items.push_back(s);
  endfunction

  function automatic void push_marker(stim_kind_e k, int pct);
    stim_t s;
    s = '{kind: k, cmd: '0, reg_sel: REG_MAP_WIDTH, value: '0, idle_pct: pct};
    pending_items.push_back(s);
  endfunction

  // flag byte plus its trailing bytes with random content; returns items added
  function automatic int push_record(logic [7:0] flag);
    int n;
    n = extra_bytes(flag);
    push_item(MODE_BYTE, flag, 16'($urandom), 16'($urandom));
    for (int i = 0; i < n; i++)
      push_item(MODE_BYTE, 8'($urandom), 16'($urandom), 16'($urandom));
    return n + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes the work list in order. An item is handed over when start
  // is high and busy low; the model is advanced at that same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    logic             nxt_start;
    logic             nxt_cfg_valid;
    cmd_t             nxt_cmd;
    logic [CFG_IDX_W-1:0] nxt_index;
    logic [CFG_W-1:0] nxt_data;
    stim_t            s;
    nxt_start     = start;
    nxt_cfg_valid = cfg_valid;
    nxt_cmd       = cmd;
    nxt_index     = cfg_index;
    nxt_data      = cfg_data;
    if (!rst) begin
      if (start && !busy) begin
        tile_results_due.push_back(predict_tile_result(cmd));
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        set_map_reg(cfg_index, cfg_data);
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_start && !nxt_cfg_valid && pending_items.size() > 0) begin
        s = pending_items[0];
        case (s.kind)
          STIM_ITEM: begin
            if ($urandom_range(99) >= idle_pct) begin
              void'(pending_items.pop_front());
              nxt_start = 1'b1;
              nxt_cmd   = s.cmd;
            end
          end
          STIM_REG: begin
            void'(pending_items.pop_front());
            nxt_cfg_valid = 1'b1;
            nxt_index     = s.reg_sel;
            nxt_data      = s.value;
          end
          STIM_DRAIN: begin
            // hold off until nothing is in flight
            if (tile_results_due.size() == 0) void'(pending_items.pop_front());
          end
          default: begin
            idle_pct = s.idle_pct;
            void'(pending_items.pop_front());
          end
        endcase
      end
    end
    start     <= nxt_start;
    cmd       <= nxt_cmd;
    cfg_valid <= nxt_cfg_valid;
    cfg_index <= nxt_index;
    cfg_data  <= nxt_data;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobe is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid) begin
      if (tile_results_due.size() == 0) begin
        flag_mismatch("result with nothing due", 1, 0);
      end else begin
        want = tile_results_due.pop_front();
        if (result.blocked !== want.blocked)
          flag_mismatch("blocked", result.blocked, want.blocked);
        if (result.cells_loaded !== want.cells_loaded)
          flag_mismatch("cells_loaded", result.cells_loaded, want.cells_loaded);
        if (result.load_complete !== want.load_complete)
          flag_mismatch("load_complete", result.load_complete, want.load_complete);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  int phase_w [10] = '{3, 512, 1, 5, 1023, 7, 0, 2, 512, 6};
  int phase_h [10] = '{3, 512, 1, 2, 1, 4, 9, 7, 1, 6};
  int pace_pct [3] = '{0, 57, 21};

  initial begin
    int          w, h, n, r, cap;
    logic [7:0]  flag;
    logic [15:0] qx, qy;
    bit          paused;

    // --- directed: 4 x 2 map, several record shapes, then queries ----------
    push_marker(STIM_PACE, 0);
    push_reg(REG_MAP_WIDTH, 4);
    push_reg(REG_MAP_HEIGHT, 2);
    push_item(MODE_NOP, 8'hFF, 16'h7FFF, 16'h8000);
    push_item(MODE_QUERY, 8'h00, 16'h0000, 16'h0000);   // nothing loaded yet
    push_item(MODE_START, 8'h00, 16'h0000, 16'h0000);
    n = push_record(8'h01);
    // flag with two extra bytes; 0xFF in the data must not count as a flag
    push_item(MODE_BYTE, 8'h03, 16'h0, 16'h0);
    push_item(MODE_BYTE, 8'hFF, 16'h0, 16'h0);
    push_item(MODE_BYTE, 8'hFF, 16'h0, 16'h0);
    n = push_record(8'hF0);
    n = push_record(8'h00);
    n = push_record(8'h01);
    n = push_record(8'h00);
    n = push_record(8'h01);
    // last cell: counted at once while its twelve extra bytes are still due
    push_item(MODE_BYTE, 8'hFF, 16'h0, 16'h0);
    push_item(MODE_QUERY, 8'h00, 16'd3, 16'd1);
    for (int i = 0; i < 12; i++)
      push_item(MODE_BYTE, 8'h01, 16'h0, 16'h0);
    push_item(MODE_BYTE, 8'h01, 16'h0, 16'h0);          // beyond the total: ignored
    push_item(MODE_QUERY, 8'h00, 16'h8000, 16'h0000);
    push_item(MODE_QUERY, 8'h00, 16'h0000, 16'hFFFF);
    push_item(MODE_QUERY, 8'h00, 16'd4, 16'd0);
    push_item(MODE_QUERY, 8'h00, 16'd0, 16'd2);
    push_item(MODE_QUERY, 8'h00, 16'h7FFF, 16'h7FFF);
    push_item(MODE_QUERY, 8'h00, 16'd1, 16'd0);

    // register change after the load, and positions past the stored bits
    push_marker(STIM_DRAIN, 0);
    push_reg(REG_MAP_WIDTH, 1023);
    push_reg(REG_MAP_HEIGHT, 1023);
    push_item(MODE_QUERY, 8'h00, 16'd0, 16'd0);
    push_item(MODE_QUERY, 8'h00, 16'd5, 16'd0);
    push_item(MODE_QUERY, 8'h00, 16'd1022, 16'd300);
    push_item(MODE_QUERY, 8'h00, 16'd1022, 16'd1022);

    // empty map: complete straight away, flags ignored
    push_marker(STIM_DRAIN, 0);
    push_reg(REG_MAP_WIDTH, 0);
    push_reg(REG_MAP_HEIGHT, 7);
    push_item(MODE_START, 8'h5A, 16'h1234, 16'h4321);
    push_item(MODE_BYTE, 8'h01, 16'h0, 16'h0);
    push_item(MODE_QUERY, 8'h00, 16'd0, 16'd0);

    // --- random phases: each a fresh map size and sender pacing ---------------
    for (int p = 0; p < 10; p++) begin
      w = phase_w[p];
      h = phase_h[p];
      paused = 1'b0;
      push_marker(STIM_DRAIN, 0);
      push_marker(STIM_PACE, pace_pct[p % 3]);
      if ($urandom_range(1)) begin
        push_reg(REG_MAP_WIDTH, w);
        push_reg(REG_MAP_HEIGHT, h);
      end else begin
        push_reg(REG_MAP_HEIGHT, h);
        push_reg(REG_MAP_WIDTH, w);
      end
      push_item(MODE_START, 8'($urandom), 16'($urandom), 16'($urandom));
      n = 1;
      while (n < 40) begin
        // one mid-phase stop until the pipe is empty
        if (p == 4 && n >= 20 && !paused) begin
          push_marker(STIM_DRAIN, 0);
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 62) begin
          // mostly short records so that small maps fill up
          flag = 8'($urandom_range(1));
          if ($urandom_range(3) == 0) flag = flag | 8'($urandom);
          n += push_record(flag);
        end else if (r < 86) begin
          if ($urandom_range(3) == 0) begin
            qx = 16'($urandom);
            qy = 16'($urandom);
          end else begin
            cap = (h < 2) ? h : 2;
            qx = 16'($urandom_range(w, 0));
            qy = $urandom_range(1) ? 16'($urandom_range(h, 0)) : 16'($urandom_range(cap, 0));
          end
          push_item(MODE_QUERY, 8'($urandom), qx, qy);
          n++;
        end else if (r < 93) begin
          push_item(MODE_BYTE, 8'($urandom), 16'($urandom), 16'($urandom));
          n++;
        end else if (r < 96) begin
          // restart in the middle of a record
          push_item(MODE_START, 8'($urandom), 16'($urandom), 16'($urandom));
          n++;
        end else begin
          push_item(MODE_NOP, 8'($urandom), 16'($urandom), 16'($urandom));
          n++;
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || start || cfg_valid || tile_results_due.size() > 0)
      @(posedge clk);
    // keep watching to catch stray strobes
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/tmbb_pkg.sv
design/tmbb_front.sv
design/tmbb_queue.sv
design/tmbb_back.sv
design/tile_map_block_bitmap_unit.sv
sim/testbench.sv
